// ===== rtl/m4rm_pkg.sv =====
// ----------------------------------------------------------------------------
// m4rm_pkg
// Shared types and constants of the 4x4 matrix row multiplier.
// ----------------------------------------------------------------------------
package m4rm_pkg;

  localparam int MAT_DIM      = 4;
  localparam int ELEM_W       = 32;
  localparam int PROD_W       = 2 * ELEM_W;
  // Four full-width products summed without overflow
  localparam int SUM_W        = PROD_W + 2;
  localparam int ROW_IDX_W    = $clog2(MAT_DIM);
  localparam int DEF_FRAC_BITS = 16;

  localparam logic signed [ELEM_W-1:0] ELEM_MAX = {1'b0, {(ELEM_W-1){1'b1}}};
  localparam logic signed [ELEM_W-1:0] ELEM_MIN = {1'b1, {(ELEM_W-1){1'b0}}};

  typedef enum logic {
    REQ_LOAD = 1'b0,
    REQ_MUL  = 1'b1
  } req_kind_t;

  typedef struct packed {
    logic                        req_type;
    logic [ROW_IDX_W-1:0]        row_index;
    logic signed [ELEM_W-1:0]    elem_0;
    logic signed [ELEM_W-1:0]    elem_1;
    logic signed [ELEM_W-1:0]    elem_2;
    logic signed [ELEM_W-1:0]    elem_3;
  } req_t;

  typedef struct packed {
    logic signed [ELEM_W-1:0]    prod_0;
    logic signed [ELEM_W-1:0]    prod_1;
    logic signed [ELEM_W-1:0]    prod_2;
    logic signed [ELEM_W-1:0]    prod_3;
    logic                        sat_flag;
  } rsp_t;

  // One row or one column of four elements
  typedef logic [MAT_DIM-1:0][ELEM_W-1:0] vec_t;
  // Whole matrix, indexed [row][column]
  typedef logic [MAT_DIM-1:0][MAT_DIM-1:0][ELEM_W-1:0] mat_t;

  // Load enables of the lane pipeline
  typedef struct packed {
    logic ld_prod;
    logic ld_sum;
  } lane_ctl_t;

  // Saturated column result of one lane
  typedef struct packed {
    logic signed [ELEM_W-1:0] value;
    logic                     sat;
  } lane_res_t;

endpackage

// ===== rtl/m4rm_store.sv =====
// ----------------------------------------------------------------------------
// m4rm_store
// Right-hand matrix store: sixteen registers, one row written per load
// request, reset to the identity matrix.
// ----------------------------------------------------------------------------
module m4rm_store #(
  parameter int FRAC_BITS = m4rm_pkg::DEF_FRAC_BITS
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              wr_en,
  input  logic [m4rm_pkg::ROW_IDX_W-1:0]    wr_row,
  input  m4rm_pkg::vec_t                    wr_data,
  output m4rm_pkg::mat_t                    mat
);
  import m4rm_pkg::*;

  localparam logic [ELEM_W-1:0] ONE = ELEM_W'(1) << FRAC_BITS;

  mat_t store;

  // Reset to identity, then overwrite one row per load
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < MAT_DIM; r++) begin
        for (int c = 0; c < MAT_DIM; c++) begin
          store[r][c] <= (r == c) ? ONE : '0;
        end
      end
    end else if (wr_en) begin
      store[wr_row] <= wr_data;
    end
  end

  assign mat = store;

endmodule

// ===== rtl/m4rm_lane.sv =====
// ----------------------------------------------------------------------------
// m4rm_lane
// One result column: four products, their exact sum, then the fraction
// shift and saturation to 32 bits.
// ----------------------------------------------------------------------------
module m4rm_lane #(
  parameter int FRAC_BITS = m4rm_pkg::DEF_FRAC_BITS
) (
  input  logic                 clk,
  input  m4rm_pkg::lane_ctl_t  ctl,
  input  m4rm_pkg::vec_t       row,
  input  m4rm_pkg::vec_t       col,
  output m4rm_pkg::lane_res_t  res
);
  import m4rm_pkg::*;

  logic signed [PROD_W-1:0]   prod [MAT_DIM];
  logic signed [SUM_W-1:0]    sum;
  logic signed [SUM_W-1:0]    sum_next;
  logic signed [SUM_W-1:0]    shifted;
  logic [SUM_W-ELEM_W:0]      upper;
  logic                       fits;

  // Stage one: full-width products
  always_ff @(posedge clk) begin
    if (ctl.ld_prod) begin
      for (int k = 0; k < MAT_DIM; k++) begin
        prod[k] <= $signed(row[k]) * $signed(col[k]);
      end
    end
  end

  // Stage two: exact sum of the products
  always_comb begin
    sum_next = '0;
    for (int k = 0; k < MAT_DIM; k++) begin
      sum_next = sum_next + SUM_W'(prod[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.ld_sum) begin
      sum <= sum_next;
    end
  end

  // Drop the fraction bits (floor) and clamp to the element range
  always_comb begin
    shifted = sum >>> FRAC_BITS;
    upper   = shifted[SUM_W-1:ELEM_W-1];
    fits    = (&upper) || !(|upper);
    res.sat = !fits;
    if (fits) begin
      res.value = shifted[ELEM_W-1:0];
    end else begin
      res.value = sum[SUM_W-1] ? ELEM_MIN : ELEM_MAX;
    end
  end

endmodule

// ===== rtl/m4rm_merge.sv =====
// ----------------------------------------------------------------------------
// m4rm_merge
// Output stage: gathers the four lane results, merges their saturation
// flags and holds the response until it is taken.
// ----------------------------------------------------------------------------
module m4rm_merge (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  m4rm_pkg::lane_res_t  lane_res [m4rm_pkg::MAT_DIM],
  output logic                 take,
  output logic                 rsp_valid,
  input  logic                 rsp_ready,
  output m4rm_pkg::rsp_t       rsp
);
  import m4rm_pkg::*;

  logic   out_valid;
  rsp_t   out_data;
  rsp_t   out_data_next;

  // Output slot is free when empty or being drained
  assign take = !out_valid || rsp_ready;

  // Combine the lanes into one response
  always_comb begin
    out_data_next.prod_0   = lane_res[0].value;
    out_data_next.prod_1   = lane_res[1].value;
    out_data_next.prod_2   = lane_res[2].value;
    out_data_next.prod_3   = lane_res[3].value;
    out_data_next.sat_flag = lane_res[0].sat || lane_res[1].sat ||
                             lane_res[2].sat || lane_res[3].sat;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take && in_valid) begin
      out_data <= out_data_next;
    end
  end

  assign rsp_valid = out_valid;
  assign rsp       = out_data;

  // A saturated response carries at least one clamped column
  a_sat_clamped: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.sat_flag) |->
      (out_data.prod_0 == ELEM_MAX || out_data.prod_0 == ELEM_MIN ||
       out_data.prod_1 == ELEM_MAX || out_data.prod_1 == ELEM_MIN ||
       out_data.prod_2 == ELEM_MAX || out_data.prod_2 == ELEM_MIN ||
       out_data.prod_3 == ELEM_MAX || out_data.prod_3 == ELEM_MIN))
    else $error("saturation flag without a clamped column");

endmodule

// ===== rtl/matrix4_row_multiply.sv =====
// ----------------------------------------------------------------------------
// matrix4_row_multiply
// Multiplies a left-hand matrix row by a stored 4x4 Q16.16 matrix.
// ----------------------------------------------------------------------------
// Usage:
//   req channel (req_valid/req_ready/req): a load request (req_type 0)
//   writes row row_index of the stored right-hand matrix and gives no
//   response; a multiply request (req_type 1) carries one left row.
//   rsp channel (rsp_valid/rsp_ready/rsp): one response per multiply,
//   four saturated columns and a saturation flag, in request order.
//   Throughput: one request per cycle unless a stalled, full pipeline holds
//   it, set by four lanes of four 32x32 multipliers each working in parallel.
//   Pipeline: a multiply's response passes the product register, the sum
//   register and the output register in turn. A load is seen by a
//   multiply accepted in the very next cycle.
//   Reset: the stored matrix returns to identity and the pipeline empties.
//   Stall: while rsp_ready is low the pipeline keeps filling its empty
//   stages; once all three hold a response req_ready drops.
// ----------------------------------------------------------------------------
module matrix4_row_multiply #(
  parameter int FRAC_BITS = m4rm_pkg::DEF_FRAC_BITS
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_ready,
  input  m4rm_pkg::req_t    req,
  output logic              rsp_valid,
  input  logic              rsp_ready,
  output m4rm_pkg::rsp_t    rsp
);
  import m4rm_pkg::*;

  logic       v1;
  logic       v2;
  logic       adv1;
  logic       adv2;
  logic       take;
  logic       accept;
  logic       load;
  logic       mul;
  vec_t       row;
  mat_t       mat;
  lane_ctl_t  ctl;
  lane_res_t  lane_res [MAT_DIM];

  // Each stage loads when empty or when its contents move on
  assign adv2      = !v2 || take;
  assign adv1      = !v1 || adv2;
  assign req_ready = adv1;
  assign accept    = req_valid && req_ready;
  assign load      = accept && (req_kind_t'(req.req_type) == REQ_LOAD);
  assign mul       = accept && (req_kind_t'(req.req_type) == REQ_MUL);

  assign row = {req.elem_3, req.elem_2, req.elem_1, req.elem_0};

  assign ctl.ld_prod = mul;
  assign ctl.ld_sum  = adv2 && v1;

  // Advance the stage valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      if (adv1) begin
        v1 <= mul;
      end
      if (adv2) begin
        v2 <= v1;
      end
    end
  end

  m4rm_store #(
    .FRAC_BITS (FRAC_BITS)
  ) u_store (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (load),
    .wr_row  (req.row_index),
    .wr_data (row),
    .mat     (mat)
  );

  // One lane per result column
  for (genvar j = 0; j < MAT_DIM; j++) begin : g_lane
    vec_t col;

    always_comb begin
      for (int k = 0; k < MAT_DIM; k++) begin
        col[k] = mat[k][j];
      end
    end

    m4rm_lane #(
      .FRAC_BITS (FRAC_BITS)
    ) u_lane (
      .clk (clk),
      .ctl (ctl),
      .row (row),
      .col (col),
      .res (lane_res[j])
    );
  end

  m4rm_merge u_merge (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v2),
    .lane_res  (lane_res),
    .take      (take),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  // A load request never enters the product stage
  a_load_no_rsp: assert property (@(posedge clk) disable iff (rst)
    load |=> !v1)
    else $error("load request entered the pipeline");

  // A full, stalled pipeline refuses requests
  a_full_blocks: assert property (@(posedge clk) disable iff (rst)
    (v1 && v2 && rsp_valid && !rsp_ready) |-> !req_ready)
    else $error("request accepted into a full pipeline");

  // A held sum stage keeps its request
  a_sum_held: assert property (@(posedge clk) disable iff (rst)
    (v2 && !take) |=> v2)
    else $error("sum stage lost a request");

endmodule
